@@ rtl/clp_pkg.sv @@
package clp_pkg;

   localparam int OPCODE_W    = 3;
   localparam int INDEX_W     = 6;
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 7;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_GET    = 3'd1,
      OP_REMOVE = 3'd2,
      OP_POP    = 3'd3,
      OP_SHIFT  = 3'd4,
      OP_NEXT   = 3'd5,
      OP_REWIND = 3'd6,
      OP_NOP    = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPACT,
      ST_DONE
   } state_type;

endpackage

@@ rtl/clp_ram.sv @@
module clp_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/clp_engine.sv @@
module clp_engine #(
   parameter int DEPTH      = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request side
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [clp_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic [clp_pkg::INDEX_W-1:0]         req_index,
   input  logic [clp_pkg::DATA_W-1:0]          req_data,
   // result side
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [clp_pkg::DATA_W-1:0]          rsp_data,
   output logic [clp_pkg::STATUS_W-1:0]        rsp_status,
   output logic [clp_pkg::COUNT_W-1:0]         rsp_count,
   // element store
   output logic                                mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]            mem_wr_addr,
   output logic [ELEM_WIDTH-1:0]               mem_wr_data,
   output logic                                mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]            mem_rd_addr,
   input  logic [ELEM_WIDTH-1:0]               mem_rd_data
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = clp_pkg::INDEX_W;
   localparam int DW     = clp_pkg::DATA_W;
   localparam int CW     = clp_pkg::COUNT_W;

   clp_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    cursor_ff, cursor_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic [ADDR_W-1:0]   dest_ff, dest_in;
   logic                pend_ff, pend_in;
   logic                shift_ff, shift_in;
   logic [DW-1:0]       res_data_ff, res_data_in;
   clp_pkg::status_type res_status_ff, res_status_in;
   logic                out_vld_ff, out_vld_in;
   logic [DW-1:0]       out_data_ff, out_data_in;
   logic [clp_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic [CW-1:0]       out_count_ff, out_count_in;

   clp_pkg::op_type     op;
   logic [CNT_W+IDX_W-1:0] idx_ext, cnt_ext;
   logic [CNT_W-1:0]    cnt_m1;
   logic                accept, idx_ok, cur_ok, is_empty, is_full, scan_more, out_free;

   assign op        = clp_pkg::op_type'(req_opcode);
   assign idx_ext   = {{CNT_W{1'b0}}, req_index};
   assign cnt_ext   = {{IDX_W{1'b0}}, count_ff};
   assign cnt_m1    = count_ff - 1'b1;
   assign idx_ok    = idx_ext < cnt_ext;
   assign cur_ok    = cursor_ff < count_ff;
   assign is_empty  = count_ff == '0;
   assign is_full   = count_ff == CNT_W'(DEPTH);
   assign scan_more = scan_ff < count_ff;
   assign out_free  = !out_vld_ff || rsp_ready;
   assign req_ready = state_ff == clp_pkg::ST_IDLE;
   assign accept    = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         clp_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = clp_pkg::ST_DONE;
               case (op)
                  clp_pkg::OP_GET:    if (idx_ok)    state_in = clp_pkg::ST_READ;
                  clp_pkg::OP_REMOVE: if (idx_ok)    state_in = clp_pkg::ST_COMPACT;
                  clp_pkg::OP_POP:    if (!is_empty) state_in = clp_pkg::ST_READ;
                  clp_pkg::OP_SHIFT:  if (!is_empty) state_in = clp_pkg::ST_READ;
                  clp_pkg::OP_NEXT:   if (cur_ok)    state_in = clp_pkg::ST_READ;
                  default:            state_in = clp_pkg::ST_DONE;
               endcase
            end
         end
         clp_pkg::ST_READ: begin
            state_in = shift_ff ? clp_pkg::ST_COMPACT : clp_pkg::ST_DONE;
         end
         clp_pkg::ST_COMPACT: begin
            if (!scan_more && !pend_ff) begin
               state_in = clp_pkg::ST_DONE;
            end
         end
         clp_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = clp_pkg::ST_IDLE;
            end
         end
         default: state_in = clp_pkg::ST_IDLE;
      endcase
   end

   // datapath and store accesses
   always_comb begin
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      scan_in       = scan_ff;
      dest_in       = dest_ff;
      pend_in       = pend_ff;
      shift_in      = shift_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      out_data_in   = out_data_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      out_vld_in    = rsp_ready ? 1'b0 : out_vld_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = count_ff[ADDR_W-1:0];
      mem_wr_data   = ELEM_WIDTH'(req_data);
      mem_rd_en     = 1'b0;
      mem_rd_addr   = idx_ext[ADDR_W-1:0];
      case (state_ff)
         clp_pkg::ST_IDLE: begin
            if (accept) begin
               res_data_in   = '0;
               res_status_in = clp_pkg::STAT_OK;
               shift_in      = 1'b0;
               case (op)
                  clp_pkg::OP_PUSH: begin
                     if (is_full) begin
                        res_status_in = clp_pkg::STAT_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  clp_pkg::OP_GET: begin
                     if (idx_ok) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = idx_ext[ADDR_W-1:0];
                     end else begin
                        res_status_in = clp_pkg::STAT_RANGE;
                     end
                  end
                  clp_pkg::OP_REMOVE: begin
                     if (idx_ok) begin
                        scan_in = CNT_W'(idx_ext + 1'b1);
                        pend_in = 1'b0;
                     end else begin
                        res_status_in = clp_pkg::STAT_RANGE;
                     end
                  end
                  clp_pkg::OP_POP: begin
                     if (is_empty) begin
                        res_status_in = clp_pkg::STAT_RANGE;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = cnt_m1[ADDR_W-1:0];
                        count_in    = cnt_m1;
                     end
                  end
                  clp_pkg::OP_SHIFT: begin
                     if (is_empty) begin
                        res_status_in = clp_pkg::STAT_RANGE;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        shift_in    = 1'b1;
                     end
                  end
                  clp_pkg::OP_NEXT: begin
                     if (cur_ok) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = cursor_ff[ADDR_W-1:0];
                        cursor_in   = cursor_ff + 1'b1;
                     end else begin
                        res_status_in = clp_pkg::STAT_RANGE;
                     end
                  end
                  clp_pkg::OP_REWIND: cursor_in = '0;
                  default: ;
               endcase
            end
         end
         clp_pkg::ST_READ: begin
            res_data_in = DW'(mem_rd_data);
            if (shift_ff) begin
               scan_in = CNT_W'(1);
               pend_in = 1'b0;
            end
         end
         clp_pkg::ST_COMPACT: begin
            // write back the entry read last cycle one place lower, read the following one
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = dest_ff;
               mem_wr_data = mem_rd_data;
            end
            if (scan_more) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = scan_ff[ADDR_W-1:0];
               dest_in     = ADDR_W'(scan_ff - 1'b1);
               scan_in     = scan_ff + 1'b1;
               pend_in     = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = cnt_m1;
               end
            end
         end
         clp_pkg::ST_DONE: begin
            if (out_free) begin
               out_vld_in    = 1'b1;
               out_data_in   = res_data_ff;
               out_status_in = res_status_ff;
               out_count_in  = CW'(count_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= clp_pkg::ST_IDLE;
         count_ff   <= '0;
         cursor_ff  <= '0;
         pend_ff    <= 1'b0;
         shift_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cursor_ff  <= cursor_in;
         pend_ff    <= pend_in;
         shift_ff   <= shift_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      dest_ff       <= dest_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      out_data_ff   <= out_data_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_data   = out_data_ff;
   assign rsp_status = out_status_ff;
   assign rsp_count  = out_count_ff;

endmodule

@@ rtl/compacting_list_store.sv @@
// Bounded ordered list of DEPTH elements of ELEM_WIDTH bits with a count and a read cursor.
// Request channel (req_): one operation per transfer; opcode on req_tuser, index and the
// value to append on req_tdata. Opcodes: push, get, remove, pop, shift, next, rewind, no-op.
// Result channel (rsp_): exactly one transfer per request, in order, carrying the element
// read (zero otherwise) and the count after the operation on rsp_tdata, status on rsp_tuser
// (ok, empty or out of range, full).
// Steps per operation, from request transfer to result transfer:
//   push, rewind, no-op and any rejected operation: straight to the result;
//   get, pop, next: a registered read of the element store, then the result;
//   remove at index i: a walk that moves entries i+1 to count-1 down, then the result;
//   shift: a read of entry 0, the same walk from entry 1, then the result.
// Remove and shift walk the store one entry per cycle through its single read port and
// single write port, so they dominate the rate.
// One operation is in work at a time; req_tready is high while the engine is idle.
// The result sits in an output register, so the next request is taken while a result
// still waits; if the receiver stalls, the following result holds in the engine until
// the output register drains.
// Reset clears the count, the cursor and the result valid; store contents are left
// undefined and are only read below the count.
module compacting_list_store #(
   parameter int DEPTH      = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [clp_pkg::REQ_TDATA_W-1:0]     req_tdata,  // index[5:0], data_in[37:6], pad
   input  logic [clp_pkg::OPCODE_W-1:0]        req_tuser,  // opcode[2:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [clp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // data_out[31:0], count[38:32], pad
   output logic [clp_pkg::STATUS_W-1:0]        rsp_tuser   // status[1:0]
);

   localparam int ADDR_W = $clog2(DEPTH);

   logic                      mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]         mem_wr_addr, mem_rd_addr;
   logic [ELEM_WIDTH-1:0]     mem_wr_data, mem_rd_data;
   logic [clp_pkg::DATA_W-1:0]  rsp_data;
   logic [clp_pkg::COUNT_W-1:0] rsp_count;

   clp_engine #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_opcode  (req_tuser),
      .req_index   (req_tdata[5:0]),
      .req_data    (req_tdata[37:6]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_data    (rsp_data),
      .rsp_status  (rsp_tuser),
      .rsp_count   (rsp_count),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   clp_ram #(
      .DEPTH (DEPTH),
      .WIDTH (ELEM_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tdata = {1'b0, rsp_count, rsp_data};

endmodule

@@ rtl/clp_chk.sv @@
module clp_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [clp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [clp_pkg::STATUS_W-1:0]    rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // a failed operation returns no element
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == clp_pkg::STAT_RANGE || rsp_tuser == clp_pkg::STAT_FULL)
      |-> rsp_tdata[31:0] == '0)
      else $error("failed operation returned data");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == clp_pkg::STAT_OK || rsp_tuser == clp_pkg::STAT_RANGE
                     || rsp_tuser == clp_pkg::STAT_FULL)
      else $error("undefined status code");

   // one operation in work at a time: drop ready after every request transfer
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an operation was in work");

   // nothing is offered in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule

bind compacting_list_store clp_chk u_clp_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ tb/compacting_list_store_tb.sv @@
module compacting_list_store_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 64;
   localparam int ELEM_WIDTH  = 32;
   localparam int STALL_LIMIT = 2000;
   localparam int INDEX_W     = clp_pkg::INDEX_W;
   localparam int DATA_W      = clp_pkg::DATA_W;
   localparam int COUNT_W     = clp_pkg::COUNT_W;

   typedef struct {
      clp_pkg::op_type    op;
      logic [INDEX_W-1:0] idx;
      logic [DATA_W-1:0]  din;
   } list_op_type;

   typedef struct {
      clp_pkg::op_type     op;
      logic [DATA_W-1:0]   data_out;
      clp_pkg::status_type status;
      logic [COUNT_W-1:0]  count;
   } list_reply_type;

   typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [clp_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [clp_pkg::OPCODE_W-1:0]    req_tuser  = clp_pkg::OP_NOP;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [clp_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [clp_pkg::STATUS_W-1:0]    rsp_tuser;

   // shadow of the list, advanced once per accepted request
   logic [ELEM_WIDTH-1:0] model_store [DEPTH];
   int model_count  = 0;
   int model_cursor = 0;

   list_op_type    op_queue[$];
   list_reply_type predicted_replies[$];

   int  gen_count    = 0;
   bit  steady_phase = 1'b0;
   int  fail_count   = 0;
   int  ops_seen [8];
   int  full_hits    = 0;
   int  range_hits   = 0;
   int  peak_count   = 0;
   int  replies_seen = 0;
   int  stall_cycles = 0;

   compacting_list_store #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // delete one entry and move every later entry down a place
   function automatic void close_gap(int pos);
      for (int k = pos + 1; k < model_count; k++) model_store[k-1] = model_store[k];
      model_count--;
   endfunction

   function automatic list_reply_type apply_list_op(list_op_type item);
      list_reply_type r;
      r.op       = item.op;
      r.data_out = '0;
      r.status   = clp_pkg::STAT_OK;
      case (item.op)
         clp_pkg::OP_PUSH: begin
            if (model_count >= DEPTH) r.status = clp_pkg::STAT_FULL;
            else begin
               model_store[model_count] = item.din;
               model_count++;
            end
         end
         clp_pkg::OP_GET: begin
            if (item.idx < model_count) r.data_out = model_store[item.idx];
            else r.status = clp_pkg::STAT_RANGE;
         end
         clp_pkg::OP_REMOVE: begin
            if (item.idx < model_count) close_gap(item.idx);
            else r.status = clp_pkg::STAT_RANGE;
         end
         clp_pkg::OP_POP: begin
            if (model_count == 0) r.status = clp_pkg::STAT_RANGE;
            else begin
               r.data_out = model_store[model_count-1];
               model_count--;
            end
         end
         clp_pkg::OP_SHIFT: begin
            if (model_count == 0) r.status = clp_pkg::STAT_RANGE;
            else begin
               r.data_out = model_store[0];
               close_gap(0);
            end
         end
         clp_pkg::OP_NEXT: begin
            if (model_cursor < model_count) begin
               r.data_out = model_store[model_cursor];
               model_cursor++;
            end else begin
               r.status = clp_pkg::STAT_RANGE;
            end
         end
         clp_pkg::OP_REWIND: model_cursor = 0;
         default: ;
      endcase
      r.count = model_count[COUNT_W-1:0];
      return r;
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 5;
         2:       return 15;
         default: return 35;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin : drive_req
      list_op_type    cur_item;
      list_reply_type reply;
      logic           busy;
      int             send_gap;
      int             send_pct;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
         send_pct = 10;
      end else begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            reply = apply_list_op(cur_item);
            predicted_replies.push_back(reply);
            ops_seen[cur_item.op]++;
            if (reply.status == clp_pkg::STAT_FULL) full_hits++;
            if (reply.status == clp_pkg::STAT_RANGE) range_hits++;
            if (model_count > peak_count) peak_count = model_count;
            busy = 1'b0;
         end
         if (steady_phase) send_pct = 0;
         else if ($urandom_range(0, 149) == 0) send_pct = pick_idle_pct();
         if (!busy) begin
            if (send_gap == 0 && $urandom_range(0, 99) < send_pct)
               send_gap = $urandom_range(1, 13);
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (op_queue.size() > 0) begin
               cur_item = op_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(clp_pkg::REQ_TDATA_W - INDEX_W - DATA_W){1'b0}},
                              cur_item.din, cur_item.idx};
               req_tuser  <= cur_item.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string field, clp_pkg::op_type op, logic [DATA_W-1:0] want,
                              logic [DATA_W-1:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s after %s: expected %h, got %h", $time, field, op.name(),
                  want, got);
      end
   endtask

   // result monitor
   always @(posedge clock) begin : watch_rsp
      list_reply_type want;
      int             recv_gap;
      int             recv_pct;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
         recv_pct = 10;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            replies_seen++;
            if (predicted_replies.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected transfer: expected none, got data %h status %0d",
                        $time, rsp_tdata[DATA_W-1:0], rsp_tuser);
            end else begin
               want = predicted_replies.pop_front();
               check_field("data_out", want.op, want.data_out, rsp_tdata[DATA_W-1:0]);
               check_field("status", want.op, DATA_W'(want.status), DATA_W'(rsp_tuser));
               check_field("count", want.op, DATA_W'(want.count),
                           DATA_W'(rsp_tdata[DATA_W+COUNT_W-1:DATA_W]));
            end
         end
         if (steady_phase) recv_pct = 0;
         else if ($urandom_range(0, 149) == 0) recv_pct = pick_idle_pct();
         if (recv_gap == 0 && $urandom_range(0, 99) < recv_pct)
            recv_gap = $urandom_range(1, 13);
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                  STALL_LIMIT, predicted_replies.size());
         $display("compacting_list_store_tb failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic add_op(clp_pkg::op_type op, logic [INDEX_W-1:0] idx,
                         logic [DATA_W-1:0] din);
      list_op_type item;
      item.op  = op;
      item.idx = idx;
      item.din = din;
      op_queue.push_back(item);
      // track the count so that indexes can be aimed inside the list
      case (op)
         clp_pkg::OP_PUSH:                   if (gen_count < DEPTH) gen_count++;
         clp_pkg::OP_REMOVE:                 if (idx < gen_count) gen_count--;
         clp_pkg::OP_POP, clp_pkg::OP_SHIFT: if (gen_count > 0) gen_count--;
         default: ;
      endcase
   endtask

   task automatic add_random_op(mix_mode_type mode);
      clp_pkg::op_type    op;
      logic [INDEX_W-1:0] idx;
      logic [DATA_W-1:0]  din;
      int                 roll;
      bit                 noise;
      roll  = $urandom_range(0, 99);
      noise = ($urandom_range(0, 99) < 8);
      if (noise) op = clp_pkg::op_type'($urandom_range(0, 7));
      else begin
         case (mode)
            MIX_FILL: begin
               if (roll < 85)      op = clp_pkg::OP_PUSH;
               else if (roll < 93) op = clp_pkg::OP_GET;
               else if (roll < 98) op = clp_pkg::OP_NEXT;
               else                op = clp_pkg::OP_REWIND;
            end
            MIX_DRAIN: begin
               if (roll < 25)      op = clp_pkg::OP_REMOVE;
               else if (roll < 45) op = clp_pkg::OP_POP;
               else if (roll < 65) op = clp_pkg::OP_SHIFT;
               else if (roll < 75) op = clp_pkg::OP_GET;
               else if (roll < 85) op = clp_pkg::OP_NEXT;
               else if (roll < 92) op = clp_pkg::OP_PUSH;
               else                op = clp_pkg::OP_REWIND;
            end
            default: begin
               if (roll < 30) op = clp_pkg::OP_PUSH;
               else           op = clp_pkg::op_type'($urandom_range(1, 6));
            end
         endcase
      end
      if (!noise && gen_count > 0) idx = INDEX_W'($urandom_range(0, gen_count - 1));
      else                         idx = INDEX_W'($urandom_range(0, 63));
      case ($urandom_range(0, 15))
         0:       din = '0;
         1:       din = '1;
         default: din = $urandom;
      endcase
      add_op(op, idx, din);
   endtask

   task automatic add_random_run(int total, mix_mode_type first);
      int           left;
      int           seg;
      mix_mode_type mode;
      left = total;
      mode = first;
      while (left > 0) begin
         seg = $urandom_range(20, 90);
         if (seg > left) seg = left;
         repeat (seg) add_random_op(mode);
         left -= seg;
         mode = mix_mode_type'($urandom_range(0, 2));
      end
   endtask

   task automatic wait_all_done();
      while (op_queue.size() > 0 || req_tvalid || predicted_replies.size() > 0)
         @(negedge clock);
   endtask

   initial begin
      foreach (ops_seen[i]) ops_seen[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty list: every read or removal is rejected
      add_op(clp_pkg::OP_POP, '0, '0);
      add_op(clp_pkg::OP_SHIFT, '0, '0);
      add_op(clp_pkg::OP_NEXT, '0, '0);
      add_op(clp_pkg::OP_GET, '0, '0);
      add_op(clp_pkg::OP_REMOVE, '0, '0);
      add_op(clp_pkg::OP_PUSH, 6'd63, 32'h0000_0000);
      add_op(clp_pkg::OP_PUSH, 6'd0, 32'hFFFF_FFFF);
      add_op(clp_pkg::OP_PUSH, 6'd21, 32'h5A5A_A5A5);
      add_op(clp_pkg::OP_GET, 6'd0, '1);
      add_op(clp_pkg::OP_GET, 6'd2, '0);
      add_op(clp_pkg::OP_GET, 6'd3, '0);
      add_op(clp_pkg::OP_GET, 6'd63, '0);
      add_op(clp_pkg::OP_NEXT, '0, '0);
      add_op(clp_pkg::OP_NEXT, '0, '0);
      add_op(clp_pkg::OP_REWIND, '0, '0);
      add_op(clp_pkg::OP_NEXT, '0, '0);
      // cursor stays put across the removal
      add_op(clp_pkg::OP_REMOVE, 6'd1, '0);
      add_op(clp_pkg::OP_NEXT, '0, '0);
      add_op(clp_pkg::OP_REMOVE, 6'd63, '0);
      add_op(clp_pkg::OP_SHIFT, '0, '0);
      add_op(clp_pkg::OP_POP, '0, '0);
      add_op(clp_pkg::OP_POP, '0, '0);
      add_op(clp_pkg::OP_NOP, 6'd63, '1);

      add_random_run(500, MIX_FILL);
      // hold the sender until the block has answered everything
      wait_all_done();
      add_random_run(350, MIX_BALANCED);
      while (op_queue.size() > 0) @(negedge clock);
      steady_phase = 1'b1;
      add_random_run(150, MIX_FILL);

      wait_all_done();
      repeat (80) @(negedge clock);

      $display("ran %0d operations: push %0d, get %0d, remove %0d, pop %0d, shift %0d, next %0d",
               replies_seen, ops_seen[clp_pkg::OP_PUSH], ops_seen[clp_pkg::OP_GET],
               ops_seen[clp_pkg::OP_REMOVE], ops_seen[clp_pkg::OP_POP],
               ops_seen[clp_pkg::OP_SHIFT], ops_seen[clp_pkg::OP_NEXT]);
      $display("rewind %0d, no-op %0d; full rejects %0d, range rejects %0d, peak count %0d",
               ops_seen[clp_pkg::OP_REWIND], ops_seen[clp_pkg::OP_NOP], full_hits,
               range_hits, peak_count);
      if (fail_count == 0) begin
         $display("compacting_list_store_tb passed");
      end else begin
         $display("compacting_list_store_tb failed");
      end
      $finish;
   end

endmodule
